// ===== rtl/tpq_pkg.sv =====
`default_nettype none
package tpq_pkg;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] arrival;
		logic [15:0] service;
		logic [7:0]  dev;
	} entry_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/tpq_in_if.sv =====
`default_nettype none
interface tpq_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  priority_req;
	logic [15:0] arrive_tick;
	logic [15:0] run_cycles;
	logic [7:0]  owner_tag;

	modport source (output valid, output operation, output priority_req,
		output arrive_tick, output run_cycles, output owner_tag, input ready);
	modport sink (input valid, input operation, input priority_req,
		input arrive_tick, input run_cycles, input owner_tag, output ready);
endinterface
`default_nettype wire

// ===== rtl/tpq_out_if.sv =====
`default_nettype none
interface tpq_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        task_valid;
	logic [7:0]  out_priority;
	logic [15:0] out_arrive_tick;
	logic [15:0] out_run_cycles;
	logic [7:0]  out_owner_tag;
	logic [4:0]  occupancy;

	modport source (output valid, output status, output task_valid, output out_priority,
		output out_arrive_tick, output out_run_cycles, output out_owner_tag,
		output occupancy, input ready);
	modport sink (input valid, input status, input task_valid, input out_priority,
		input out_arrive_tick, input out_run_cycles, input out_owner_tag,
		input occupancy, output ready);
endinterface
`default_nettype wire

// ===== rtl/tpq_cell.sv =====
`default_nettype none
module tpq_cell
	import tpq_pkg::*;
(
	input  wire logic   clk,
	input  wire ctrl_t  ctrl,
	input  wire logic   occupied,
	input  wire entry_t new_entry,
	input  wire entry_t left_entry,
	input  wire logic   left_ahead,
	input  wire entry_t right_entry,
	output entry_t      slot_q,
	output logic        ahead
);

	// stored entry stays ahead of the incoming one
	always_comb begin
		ahead = occupied && ((slot_q.prio > new_entry.prio) ||
			((slot_q.prio == new_entry.prio) && (slot_q.arrival < new_entry.arrival)));
	end

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!ahead) begin
				if (left_ahead) begin
					slot_q <= new_entry;
				end else begin
					slot_q <= left_entry;
				end
			end
		end else if (ctrl.deq) begin
			slot_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/task_priority_queue.sv =====
// result: a result word is registered and appears in the cycle after its input word is accepted
// throughput: one enqueue or dequeue per cycle while results are taken; all cells shift in the same cycle
// the next word is taken while a result waits, as long as that result is taken too
// reset: arst_n clears the task count and the result valid flag; slot contents stay
// undefined until written, and only slots below the count ever reach a result word
`default_nettype none
module task_priority_queue
	import tpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tpq_in_if.sink    req,
	tpq_out_if.source rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]   count_q;
	logic            fire;
	logic            is_full;
	logic            is_empty;
	ctrl_t           ctrl;
	entry_t          new_entry;
	entry_t          slot_v [QUEUE_DEPTH];
	logic            ahead_v [QUEUE_DEPTH+1];
	logic [CW-1:0]   count_next;

	logic            ovalid_q;
	status_t         status_q;
	logic            tvalid_q;
	entry_t          oentry_q;
	logic [4:0]      occ_q;

	assign req.ready = !ovalid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_full   = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);

	assign ctrl.enq = fire && (op_t'(req.operation) == OP_ENQ) && !is_full;
	assign ctrl.deq = fire && (op_t'(req.operation) == OP_DEQ) && !is_empty;

	assign new_entry = '{prio: req.priority_req, arrival: req.arrive_tick,
		service: req.run_cycles, dev: req.owner_tag};

	assign ahead_v[0] = 1'b1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		tpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CW'(i)),
			.new_entry   (new_entry),
			.left_entry  (slot_v[(i == 0) ? 0 : i - 1]),
			.left_ahead  (ahead_v[i]),
			.right_entry (slot_v[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
			.slot_q      (slot_v[i]),
			.ahead       (ahead_v[i+1])
		);
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.enq) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.deq) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (fire) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (fire) begin
			occ_q    <= 5'(count_next);
			tvalid_q <= ctrl.deq;
			if (ctrl.deq) begin
				oentry_q <= slot_v[0];
			end else begin
				oentry_q <= '0;
			end
			if (ctrl.enq || ctrl.deq) begin
				status_q <= ST_OK;
			end else if (op_t'(req.operation) == OP_ENQ) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_EMPTY;
			end
		end
	end

	assign rsp.valid           = ovalid_q;
	assign rsp.status          = status_q;
	assign rsp.task_valid      = tvalid_q;
	assign rsp.out_priority    = oentry_q.prio;
	assign rsp.out_arrive_tick = oentry_q.arrival;
	assign rsp.out_run_cycles  = oentry_q.service;
	assign rsp.out_owner_tag   = oentry_q.dev;
	assign rsp.occupancy       = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("task count above depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (op_t'(req.operation) == OP_ENQ) && is_full) |=>
		($stable(count_q) && rsp.valid && (rsp.status == ST_FULL)))
		else $error("enqueue into full queue not dropped");

	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.deq |=> (rsp.valid && rsp.task_valid && (rsp.status == ST_OK)))
		else $error("dequeue did not return a task");

	a_enq_ahead_chain: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> (count_q == $past(count_q) + CW'(1)))
		else $error("enqueue did not grow the queue");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import tpq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int QUIET_LIMIT = 1000;
	localparam int LONG_HOLD = 200;

	typedef struct packed {
		status_t    status;
		logic       task_valid;
		entry_t     job;
		logic [4:0] occupancy;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	tpq_in_if  req_if ();
	tpq_out_if rsp_if ();

	task_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	entry_t      queue_slots [QUEUE_DEPTH];
	int unsigned queue_count = 0;
	outcome_t    pending_outcomes [$];
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	// new job goes ahead of every stored job with the same keys
	function automatic bit stored_goes_first(entry_t stored, entry_t job);
		if (stored.prio != job.prio)
			return stored.prio > job.prio;
		return stored.arrival < job.arrival;
	endfunction

	function automatic outcome_t apply_queue_op(op_t op, entry_t job);
		outcome_t res;
		int unsigned pos;
		res = '0;
		res.status = ST_OK;
		if (op == OP_ENQ) begin
			if (queue_count >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < queue_count && stored_goes_first(queue_slots[pos], job))
					pos++;
				for (int k = queue_count; k > pos; k--)
					queue_slots[k] = queue_slots[k - 1];
				queue_slots[pos] = job;
				queue_count++;
			end
		end else begin
			if (queue_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.task_valid = 1'b1;
				res.job = queue_slots[0];
				for (int k = 1; k < queue_count; k++)
					queue_slots[k - 1] = queue_slots[k];
				queue_count--;
			end
		end
		res.occupancy = queue_count[4:0];
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		error_count++;
	endtask

	// check result words, then predict from the accepted request word
	always @(posedge clk) begin
		outcome_t want;
		entry_t job;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("result word with none pending", 1, 0);
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_if.status !== want.status)
					flag_mismatch("status", rsp_if.status, want.status);
				if (rsp_if.task_valid !== want.task_valid)
					flag_mismatch("task_valid", rsp_if.task_valid, want.task_valid);
				if (rsp_if.out_priority !== want.job.prio)
					flag_mismatch("out_priority", rsp_if.out_priority, want.job.prio);
				if (rsp_if.out_arrive_tick !== want.job.arrival)
					flag_mismatch("out_arrive_tick", rsp_if.out_arrive_tick,
						want.job.arrival);
				if (rsp_if.out_run_cycles !== want.job.service)
					flag_mismatch("out_run_cycles", rsp_if.out_run_cycles,
						want.job.service);
				if (rsp_if.out_owner_tag !== want.job.dev)
					flag_mismatch("out_owner_tag", rsp_if.out_owner_tag,
						want.job.dev);
				if (rsp_if.occupancy !== want.occupancy)
					flag_mismatch("occupancy", rsp_if.occupancy, want.occupancy);
			end
		end
		if (arst_n && req_if.valid && req_if.ready) begin
			job.prio = req_if.priority_req;
			job.arrival = req_if.arrive_tick;
			job.service = req_if.run_cycles;
			job.dev = req_if.owner_tag;
			pending_outcomes.push_back(apply_queue_op(op_t'(req_if.operation), job));
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side ready, with random stalls and one long hold on request
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input op_t op, input entry_t job);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.operation <= op;
		req_if.priority_req <= job.prio;
		req_if.arrive_tick <= job.arrival;
		req_if.run_cycles <= job.service;
		req_if.owner_tag <= job.dev;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// narrow keys give many ties
	function automatic entry_t random_job(bit narrow);
		entry_t job;
		job.prio = narrow ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
		job.arrival = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
		job.service = 16'($urandom_range(0, 65535));
		job.dev = 8'($urandom_range(0, 255));
		return job;
	endfunction

	function automatic op_t random_op(int unsigned enq_pct);
		return ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
	endfunction

	task automatic test_directed();
		send_word(OP_DEQ, '0);
		send_word(OP_ENQ, entry_t'{8'd255, 16'd0, 16'hffff, 8'hff});
		send_word(OP_ENQ, entry_t'{8'd0, 16'hffff, 16'd0, 8'd0});
		send_word(OP_ENQ, entry_t'{8'd128, 16'd100, 16'd1, 8'd1});
		send_word(OP_ENQ, entry_t'{8'd128, 16'd100, 16'd2, 8'd2});
		send_word(OP_ENQ, entry_t'{8'd128, 16'd99, 16'd3, 8'd3});
		send_word(OP_ENQ, entry_t'{8'd128, 16'd101, 16'd4, 8'd4});
		send_word(OP_ENQ, entry_t'{8'd255, 16'hffff, 16'd5, 8'd5});
		send_word(OP_ENQ, entry_t'{8'd0, 16'd0, 16'd6, 8'd6});
		repeat (QUEUE_DEPTH - 8)
			send_word(OP_ENQ, random_job(1'b1));
		send_word(OP_ENQ, entry_t'{8'd255, 16'd0, 16'd7, 8'd7});
		repeat (4)
			send_word(OP_DEQ, random_job(1'b0));
	endtask

	task automatic test_random_mix();
		int unsigned enq_pct;
		bit narrow;
		for (int chunk = 0; chunk < 18; chunk++) begin
			case (chunk % 3)
				0: enq_pct = 80;
				1: enq_pct = 25;
				default: enq_pct = 55;
			endcase
			narrow = ($urandom_range(0, 2) == 0);
			repeat (40)
				send_word(random_op(enq_pct), random_job(narrow));
		end
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (40)
			send_word(random_op(70), random_job(1'($urandom_range(0, 1))));
	endtask

	task automatic test_steady();
		idle_on = 1'b0;
		repeat (150)
			send_word(random_op(50), random_job(1'($urandom_range(0, 1))));
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.operation = OP_ENQ;
		req_if.priority_req = '0;
		req_if.arrive_tick = '0;
		req_if.run_cycles = '0;
		req_if.owner_tag = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_mix();
		test_backpressure();
		test_steady();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== task_priority_queue.f =====
rtl/tpq_pkg.sv
rtl/tpq_in_if.sv
rtl/tpq_out_if.sv
rtl/tpq_cell.sv
rtl/task_priority_queue.sv
dv/tb.sv
